// ===== hdl/bhe_pkg.sv =====
// Shared constants, state encoding and control structs for the byte histogram entropy block.
package bhe_pkg;

    localparam int MAX_BYTES_DEF = 4096;
    localparam int NUM_BINS      = 256;
    localparam int BIN_AW        = 8;
    localparam int LOG_FRAC      = 28;
    localparam int OUT_FRAC      = 12;
    localparam int KW            = 5;
    localparam int LOGW          = KW + LOG_FRAC;
    localparam int MANT_W        = 31;
    localparam int HALF_W        = 16;
    localparam int Q_BITS        = 17;
    localparam int ENT_W         = 16;
    localparam int CNT_OUT_W     = 13;
    localparam int ENT_MAX       = 8 << OUT_FRAC;
    localparam int IT_W          = 5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_RUN,
        S_SETTLE,
        S_NLOAD,
        S_SQ,
        S_MLO,
        S_MHI,
        S_BREAD,
        S_BCHK,
        S_DIVINIT,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              clr_wr;
        logic              byte_en;
        logic              load_n;
        logic              load_bin;
        logic              sq;
        logic              mul_lo;
        logic              mul_hi;
        logic              sub;
        logic              bin_rd;
        logic              div_init;
        logic              div_step;
        logic              out_load;
        logic [BIN_AW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic bin_zero;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/bhe_dp.sv =====
// Datapath: histogram memory, byte counters, log2 unit, accumulator, divider, output register.
module bhe_dp #(
    parameter int MAX_BYTES = bhe_pkg::MAX_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bhe_pkg::t_cmd                  i_cmd,
    output bhe_pkg::t_stat                 o_stat,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic [bhe_pkg::ENT_W-1:0]      o_entropy_fixed,
    output logic [bhe_pkg::CNT_OUT_W-1:0]  o_byte_count,
    output logic                           o_overflow
);

    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int AW = CW + bhe_pkg::LOGW + 1;
    localparam int DW = CW + bhe_pkg::LOG_FRAC - bhe_pkg::OUT_FRAC;
    localparam int MW = bhe_pkg::MANT_W;
    localparam int QB = bhe_pkg::Q_BITS;

    logic [CW-1:0] mem [bhe_pkg::NUM_BINS];

    logic [CW-1:0]              r_rd_data;
    logic                       r_p_valid;
    logic [bhe_pkg::BIN_AW-1:0] r_p_addr;
    logic                       r_w_valid;
    logic [bhe_pkg::BIN_AW-1:0] r_w_addr;
    logic [CW-1:0]              r_w_data;
    logic [CW-1:0]              r_seen;
    logic                       r_drop;

    logic [CW-1:0]                  r_x;
    logic [bhe_pkg::KW-1:0]         r_k;
    logic [MW-1:0]                  r_m;
    logic [bhe_pkg::LOG_FRAC-1:0]   r_frac;
    logic signed [AW-1:0]           r_acc;
    logic [DW-1:0]                  r_rem;
    logic [QB-1:0]                  r_lo;
    logic [QB-1:0]                  r_q;

    logic                         r_o_valid;
    logic [bhe_pkg::ENT_W-1:0]    r_o_ent;
    logic [bhe_pkg::CNT_OUT_W-1:0] r_o_cnt;
    logic                         r_o_ovf;

    logic                       counting;
    logic [CW-1:0]              cur;
    logic [CW-1:0]              bin_new;
    logic [bhe_pkg::BIN_AW-1:0] rd_addr;
    logic [CW-1:0]              x_src;
    logic [bhe_pkg::KW-1:0]     k_src;
    logic [MW-1:0]              x_ext;
    logic [2*MW-1:0]            sq;
    logic [MW:0]                sq_s;
    logic [bhe_pkg::LOGW-1:0]   log_v;
    logic [CW+bhe_pkg::HALF_W-1:0]   p_lo;
    logic [CW+bhe_pkg::LOGW-bhe_pkg::HALF_W-1:0] p_hi;
    logic signed [AW-1:0]       addend;
    logic [AW-1:0]              num;
    logic [DW:0]                r2;
    logic [DW:0]                dd;
    logic [QB-1:0]              q_clamp;

    assign counting = (r_seen < CW'(MAX_BYTES));
    assign cur      = (r_w_valid && (r_w_addr == r_p_addr)) ? r_w_data : r_rd_data;
    assign bin_new  = cur + CW'(1);
    assign rd_addr  = i_cmd.bin_rd ? i_cmd.addr : i_data_byte;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr || i_cmd.bin_rd) begin
            mem[i_cmd.addr] <= '0;
        end else if (r_p_valid) begin
            mem[r_p_addr] <= bin_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_w_valid <= 1'b0;
            r_seen    <= '0;
            r_drop    <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.byte_en && counting;
            r_w_valid <= r_p_valid;
            if (i_cmd.out_load) begin
                r_seen <= '0;
                r_drop <= 1'b0;
            end else if (i_cmd.byte_en) begin
                if (counting) begin
                    r_seen <= r_seen + CW'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_addr <= i_data_byte;
        r_w_addr <= r_p_addr;
        r_w_data <= bin_new;
    end

    // log2 mantissa setup and repeated squaring, product terms, divider terms and output clamp
    always_comb begin
        x_src = i_cmd.load_n ? r_seen : r_rd_data;
        k_src = '0;
        for (int i = 0; i < CW; i++) begin
            if (x_src[i]) begin
                k_src = bhe_pkg::KW'(i);
            end
        end
        x_ext = MW'(x_src);
        sq    = r_m * r_m;
        sq_s  = sq[2*MW-1:MW-1];
        log_v = {r_k, r_frac};
        p_lo  = r_x * log_v[bhe_pkg::HALF_W-1:0];
        p_hi  = r_x * log_v[bhe_pkg::LOGW-1:bhe_pkg::HALF_W];
        if (i_cmd.mul_hi) begin
            addend = $signed(AW'(p_hi) << bhe_pkg::HALF_W);
        end else begin
            addend = $signed(AW'(p_lo));
        end
        num = (r_acc[AW-1] ? '0 : AW'(r_acc))
            + (AW'(r_seen) << (bhe_pkg::LOG_FRAC - bhe_pkg::OUT_FRAC - 1));
        r2  = {r_rem, r_lo[QB-1]};
        dd  = (DW+1)'(r_seen) << (bhe_pkg::LOG_FRAC - bhe_pkg::OUT_FRAC);
        q_clamp = (r_q > QB'(bhe_pkg::ENT_MAX)) ? QB'(bhe_pkg::ENT_MAX) : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_n || i_cmd.load_bin) begin
            r_x    <= x_src;
            r_k    <= k_src;
            r_m    <= x_ext << (bhe_pkg::KW'(MW - 1) - k_src);
            r_frac <= '0;
        end else if (i_cmd.sq) begin
            if (sq_s[MW]) begin
                r_m    <= sq_s[MW:1];
                r_frac <= {r_frac[bhe_pkg::LOG_FRAC-2:0], 1'b1};
            end else begin
                r_m    <= sq_s[MW-1:0];
                r_frac <= {r_frac[bhe_pkg::LOG_FRAC-2:0], 1'b0};
            end
        end
        if (i_cmd.load_n) begin
            r_acc <= '0;
        end else if (i_cmd.mul_lo || i_cmd.mul_hi) begin
            r_acc <= i_cmd.sub ? (r_acc - addend) : (r_acc + addend);
        end
        if (i_cmd.div_init) begin
            r_rem <= DW'(num >> QB);
            r_lo  <= num[QB-1:0];
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_lo <= {r_lo[QB-2:0], 1'b0};
            if (r2 >= dd) begin
                r_rem <= DW'(r2 - dd);
                r_q   <= {r_q[QB-2:0], 1'b1};
            end else begin
                r_rem <= r2[DW-1:0];
                r_q   <= {r_q[QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_ent <= bhe_pkg::ENT_W'(q_clamp);
            r_o_cnt <= bhe_pkg::CNT_OUT_W'(r_seen);
            r_o_ovf <= r_drop;
        end
    end

    assign o_stat.bin_zero = (r_rd_data == '0);
    assign o_stat.out_free = !r_o_valid || i_ready;
    assign o_valid         = r_o_valid;
    assign o_entropy_fixed = r_o_ent;
    assign o_byte_count    = r_o_cnt;
    assign o_overflow      = r_o_ovf;

endmodule

// ===== hdl/bhe_ctrl.sv =====
// Controller: sequences clearing, byte intake, log2/accumulate per bin, division and output.
module bhe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_end_of_set,
    output logic           o_ready,
    input  bhe_pkg::t_stat i_stat,
    output bhe_pkg::t_cmd  o_cmd
);

    bhe_pkg::t_state            r_state, n_state;
    logic [bhe_pkg::BIN_AW-1:0] r_addr, n_addr;
    logic [bhe_pkg::IT_W-1:0]   r_it, n_it;
    logic                       r_is_bin, n_is_bin;
    logic                       accept;
    logic                       addr_last;

    assign accept    = i_valid && (r_state == bhe_pkg::S_RUN);
    assign addr_last = (r_addr == bhe_pkg::BIN_AW'(bhe_pkg::NUM_BINS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bhe_pkg::S_CLEAR;
            r_addr   <= '0;
            r_it     <= '0;
            r_is_bin <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_it     <= n_it;
            r_is_bin <= n_is_bin;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_it     = r_it;
        n_is_bin = r_is_bin;
        unique case (r_state)
            bhe_pkg::S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (addr_last) begin
                    n_state = bhe_pkg::S_RUN;
                end
            end
            bhe_pkg::S_RUN: begin
                if (accept && i_end_of_set) begin
                    n_state = bhe_pkg::S_SETTLE;
                end
            end
            bhe_pkg::S_SETTLE: n_state = bhe_pkg::S_NLOAD;
            bhe_pkg::S_NLOAD: begin
                n_is_bin = 1'b0;
                n_it     = '0;
                n_state  = bhe_pkg::S_SQ;
            end
            bhe_pkg::S_SQ: begin
                n_it = r_it + 1'b1;
                if (r_it == bhe_pkg::IT_W'(bhe_pkg::LOG_FRAC - 1)) begin
                    n_state = bhe_pkg::S_MLO;
                end
            end
            bhe_pkg::S_MLO: n_state = bhe_pkg::S_MHI;
            bhe_pkg::S_MHI: begin
                if (!r_is_bin) begin
                    n_addr  = '0;
                    n_state = bhe_pkg::S_BREAD;
                end else if (addr_last) begin
                    n_state = bhe_pkg::S_DIVINIT;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = bhe_pkg::S_BREAD;
                end
            end
            bhe_pkg::S_BREAD: n_state = bhe_pkg::S_BCHK;
            bhe_pkg::S_BCHK: begin
                if (!i_stat.bin_zero) begin
                    n_is_bin = 1'b1;
                    n_it     = '0;
                    n_state  = bhe_pkg::S_SQ;
                end else if (addr_last) begin
                    n_state = bhe_pkg::S_DIVINIT;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = bhe_pkg::S_BREAD;
                end
            end
            bhe_pkg::S_DIVINIT: begin
                n_it    = '0;
                n_state = bhe_pkg::S_DIV;
            end
            bhe_pkg::S_DIV: begin
                n_it = r_it + 1'b1;
                if (r_it == bhe_pkg::IT_W'(bhe_pkg::Q_BITS - 1)) begin
                    n_state = bhe_pkg::S_OUT;
                end
            end
            bhe_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = bhe_pkg::S_RUN;
                end
            end
            default: n_state = bhe_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.addr = r_addr;
        o_cmd.sub  = r_is_bin;
        o_ready    = 1'b0;
        unique case (r_state)
            bhe_pkg::S_CLEAR:   o_cmd.clr_wr = 1'b1;
            bhe_pkg::S_RUN: begin
                o_ready       = 1'b1;
                o_cmd.byte_en = accept;
            end
            bhe_pkg::S_SETTLE:  o_cmd.sub = 1'b0;
            bhe_pkg::S_NLOAD:   o_cmd.load_n = 1'b1;
            bhe_pkg::S_SQ:      o_cmd.sq = 1'b1;
            bhe_pkg::S_MLO:     o_cmd.mul_lo = 1'b1;
            bhe_pkg::S_MHI:     o_cmd.mul_hi = 1'b1;
            bhe_pkg::S_BREAD:   o_cmd.bin_rd = 1'b1;
            bhe_pkg::S_BCHK:    o_cmd.load_bin = !i_stat.bin_zero;
            bhe_pkg::S_DIVINIT: o_cmd.div_init = 1'b1;
            bhe_pkg::S_DIV:     o_cmd.div_step = 1'b1;
            bhe_pkg::S_OUT:     o_cmd.out_load = i_stat.out_free;
            default:            o_cmd.clr_wr = 1'b0;
        endcase
    end

endmodule

// ===== hdl/byte_histogram_entropy.sv =====
// Intake: a byte per cycle while o_ready is high; the end_of_set byte starts the entropy pass.
// Entropy pass: log2 and accumulate for the byte count and for each non-empty bin on the
// shared log2 squaring unit (28 squarings per count), then the 17-step divider.
// Bytes stall in clearing, the entropy pass and until a result is taken; output is registered.
// Reset: synchronous, active low; a clearing pass over all 256 bins of the histogram follows.
module byte_histogram_entropy #(
    parameter int MAX_BYTES = bhe_pkg::MAX_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_end_of_set,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bhe_pkg::ENT_W-1:0]      o_entropy_fixed,
    output logic [bhe_pkg::CNT_OUT_W-1:0]  o_byte_count,
    output logic                           o_overflow
);

    bhe_pkg::t_cmd  cmd;
    bhe_pkg::t_stat stat;

    bhe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_end_of_set (i_end_of_set),
        .o_ready      (o_ready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    bhe_dp #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_data_byte     (i_data_byte),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_entropy_fixed (o_entropy_fixed),
        .o_byte_count    (o_byte_count),
        .o_overflow      (o_overflow)
    );

endmodule
